FILE: src/mped_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak event detector package
// Shared constants, register indexes, queue operation codes and the
// configuration bundle of the multichannel peak event detector.
// ----------------------------------------------------------------------------
package mped_pkg;

   localparam int CHANNELS_DEFAULT    = 16;
   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int COUNT_BITS_DEFAULT  = 8;

   localparam int CHANNEL_BITS   = 4;
   localparam int THRESHOLD_BITS = 24;
   localparam int CFG_COUNT_BITS = 8;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int OP_BITS     = 2;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 24'd4194304;
   localparam logic [CFG_COUNT_BITS-1:0] CONFIRM_RESET   = 8'd2;
   localparam logic [CFG_COUNT_BITS-1:0] RECOVER_RESET   = 8'd4;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_CONFIRM   = 2'd1,
      REG_RECOVER   = 2'd2
   } reg_index_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_SAMPLE    = 2'd0,
      OP_BATCH_END = 2'd1,
      OP_CLEAR     = 2'd2
   } op_type;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] threshold;
      logic [CFG_COUNT_BITS-1:0] confirm_batches;
      logic [CFG_COUNT_BITS-1:0] recover_batches;
   } cfg_type;

endpackage

FILE: src/mped_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak event detector register file
// Holds the threshold and the confirmation and recovery counts behind an
// APB-style port whose ready is always high.
// ----------------------------------------------------------------------------
module mped_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mped_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mped_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mped_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output mped_pkg::cfg_type                     cfg
);

   logic [mped_pkg::THRESHOLD_BITS-1:0] threshold_ff, threshold_in;
   logic [mped_pkg::CFG_COUNT_BITS-1:0] confirm_ff, confirm_in;
   logic [mped_pkg::CFG_COUNT_BITS-1:0] recover_ff, recover_in;
   logic [1:0]                          reg_index;
   logic                                write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[mped_pkg::CSR_ADDR_BITS-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      confirm_in   = confirm_ff;
      recover_in   = recover_ff;
      csr_prdata   = '0;
      case (reg_index)
         mped_pkg::REG_THRESHOLD: begin
            if (write_en) begin
               threshold_in = csr_pwdata[mped_pkg::THRESHOLD_BITS-1:0];
            end
            csr_prdata = mped_pkg::CSR_DATA_BITS'(threshold_ff);
         end
         mped_pkg::REG_CONFIRM: begin
            if (write_en) begin
               confirm_in = csr_pwdata[mped_pkg::CFG_COUNT_BITS-1:0];
            end
            csr_prdata = mped_pkg::CSR_DATA_BITS'(confirm_ff);
         end
         mped_pkg::REG_RECOVER: begin
            if (write_en) begin
               recover_in = csr_pwdata[mped_pkg::CFG_COUNT_BITS-1:0];
            end
            csr_prdata = mped_pkg::CSR_DATA_BITS'(recover_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mped_pkg::THRESHOLD_RESET;
         confirm_ff   <= mped_pkg::CONFIRM_RESET;
         recover_ff   <= mped_pkg::RECOVER_RESET;
      end else begin
         threshold_ff <= threshold_in;
         confirm_ff   <= confirm_in;
         recover_ff   <= recover_in;
      end
   end

   assign cfg.threshold       = threshold_ff;
   assign cfg.confirm_batches = confirm_ff;
   assign cfg.recover_batches = recover_ff;

endmodule

FILE: src/mped_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak event detector front end
// Accepts requests, classifies them as sample, batch end or clear, drops
// channels outside the configured range and forms the sample magnitude.
// ----------------------------------------------------------------------------
module mped_front #(
   parameter int CHANNELS    = mped_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = mped_pkg::SAMPLE_BITS_DEFAULT,
   parameter int REQ_W       = 32,
   parameter int ENTRY_W     = 30
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               req_tlast,
   input  logic               req_tuser,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ENTRY_W-1:0] push_data
);

   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W    =
      ((mped_pkg::CHANNEL_BITS > IDX_BITS) ? mped_pkg::CHANNEL_BITS : IDX_BITS) + 1;

   logic [mped_pkg::CHANNEL_BITS-1:0] channel;
   logic [mped_pkg::CHANNEL_BITS-1:0] entry_channel;
   logic [SAMPLE_BITS-1:0]            sample;
   logic [SAMPLE_BITS-1:0]            magnitude;
   logic                              in_range;
   mped_pkg::op_type                  op;

   assign channel = req_tdata[mped_pkg::CHANNEL_BITS-1:0];
   assign sample  = req_tdata[mped_pkg::CHANNEL_BITS+SAMPLE_BITS-1:mped_pkg::CHANNEL_BITS];

   // The most negative sample keeps its full magnitude as an unsigned value.
   assign magnitude = sample[SAMPLE_BITS-1] ? ('0 - sample) : sample;
   assign in_range  = CMP_W'(channel) < CMP_W'(CHANNELS);

   always_comb begin
      if (req_tuser) begin
         op            = mped_pkg::OP_CLEAR;
         entry_channel = '0;
      end else if (req_tlast) begin
         op            = mped_pkg::OP_BATCH_END;
         entry_channel = channel;
      end else begin
         op            = mped_pkg::OP_SAMPLE;
         entry_channel = channel;
      end
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && (req_tuser || in_range);
   assign push_data  = {magnitude, entry_channel, op};

endmodule

FILE: src/mped_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak event detector request queue
// A short first-in first-out queue that lets the front end and the back end
// stall independently.
// ----------------------------------------------------------------------------
module mped_queue #(
   parameter int WIDTH = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(mped_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] slot_ff [mped_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(mped_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/mped_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak event detector back end
// Reads the channel state from memory, updates the running peak and the
// batch counters, writes the state back and presents one response per batch.
// ----------------------------------------------------------------------------
module mped_back #(
   parameter int CHANNELS    = mped_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = mped_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = mped_pkg::COUNT_BITS_DEFAULT,
   parameter int ENTRY_W     = 30,
   parameter int RSP_W       = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  mped_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata
);

   localparam int CB       = mped_pkg::CHANNEL_BITS;
   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_W     = (CB > IDX_BITS) ? CB : IDX_BITS;
   localparam int REC_W    = SAMPLE_BITS + 2 * COUNT_BITS + 1;
   localparam int TW       =
      (SAMPLE_BITS > mped_pkg::THRESHOLD_BITS) ? SAMPLE_BITS : mped_pkg::THRESHOLD_BITS;
   localparam int KW       =
      (COUNT_BITS > mped_pkg::CFG_COUNT_BITS) ? COUNT_BITS : mped_pkg::CFG_COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [REC_W-1:0] state_mem [CHANNELS];

   mped_pkg::op_type       head_op;
   logic [CB-1:0]          head_ch;
   logic [SAMPLE_BITS-1:0] head_mag;
   logic [CH_W-1:0]        head_wide;
   logic [IDX_BITS-1:0]    head_idx;

   logic                   e_valid_ff, e_valid_in;
   mped_pkg::op_type       e_op_ff;
   logic [CB-1:0]          e_ch_ff;
   logic [SAMPLE_BITS-1:0] e_mag_ff;
   logic [REC_W-1:0]       rdata_ff;
   logic                   fwd_ff, fwd_in;
   logic [REC_W-1:0]       fwd_rec_ff;
   logic [CH_W-1:0]        e_wide;
   logic [IDX_BITS-1:0]    e_idx;

   logic [CHANNELS-1:0]    valid_ff, valid_in;

   logic [REC_W-1:0]       cur_rec;
   logic [SAMPLE_BITS-1:0] cur_peak;
   logic [COUNT_BITS-1:0]  cur_abn;
   logic [COUNT_BITS-1:0]  cur_nrm;
   logic                   cur_det;
   logic [SAMPLE_BITS-1:0] peak_max;
   logic                   abnormal;
   logic [COUNT_BITS-1:0]  abn_inc;
   logic [COUNT_BITS-1:0]  nrm_inc;
   logic [mped_pkg::CFG_COUNT_BITS-1:0] confirm;
   logic [mped_pkg::CFG_COUNT_BITS-1:0] recover;
   logic [SAMPLE_BITS-1:0] new_peak;
   logic [COUNT_BITS-1:0]  new_abn;
   logic [COUNT_BITS-1:0]  new_nrm;
   logic                   new_det;
   logic [REC_W-1:0]       new_rec;

   logic                   is_end;
   logic                   out_free;
   logic                   commit;
   logic                   e_advance;
   logic                   pop;
   logic                   writes;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]          rsp_ch_ff;
   logic [SAMPLE_BITS-1:0] rsp_peak_ff;
   logic                   rsp_abn_ff;
   logic                   rsp_det_ff;
   logic                   rsp_chg_ff;

   assign head_op   = mped_pkg::op_type'(q_data[mped_pkg::OP_BITS-1:0]);
   assign head_ch   = q_data[mped_pkg::OP_BITS+CB-1:mped_pkg::OP_BITS];
   assign head_mag  = q_data[ENTRY_W-1:mped_pkg::OP_BITS+CB];
   assign head_wide = CH_W'(head_ch);
   assign head_idx  = head_wide[IDX_BITS-1:0];
   assign e_wide    = CH_W'(e_ch_ff);
   assign e_idx     = e_wide[IDX_BITS-1:0];

   // A write from the previous request to the same channel is not yet in the
   // registered read data, so it is taken from the forwarding register.
   assign cur_rec  = fwd_ff ? fwd_rec_ff : (valid_ff[e_idx] ? rdata_ff : '0);
   assign cur_peak = cur_rec[SAMPLE_BITS-1:0];
   assign cur_abn  = cur_rec[SAMPLE_BITS+COUNT_BITS-1:SAMPLE_BITS];
   assign cur_nrm  = cur_rec[SAMPLE_BITS+2*COUNT_BITS-1:SAMPLE_BITS+COUNT_BITS];
   assign cur_det  = cur_rec[REC_W-1];

   assign peak_max = (e_mag_ff > cur_peak) ? e_mag_ff : cur_peak;
   assign abnormal = TW'(peak_max) > TW'(cfg.threshold);
   assign abn_inc  = (cur_abn < COUNT_MAX) ? cur_abn + COUNT_BITS'(1) : cur_abn;
   assign nrm_inc  = (cur_nrm < COUNT_MAX) ? cur_nrm + COUNT_BITS'(1) : cur_nrm;
   assign confirm  = (cfg.confirm_batches == '0) ?
                     mped_pkg::CFG_COUNT_BITS'(1) : cfg.confirm_batches;
   assign recover  = (cfg.recover_batches == '0) ?
                     mped_pkg::CFG_COUNT_BITS'(1) : cfg.recover_batches;

   always_comb begin
      new_peak = cur_peak;
      new_abn  = cur_abn;
      new_nrm  = cur_nrm;
      new_det  = cur_det;
      case (e_op_ff)
         mped_pkg::OP_SAMPLE: begin
            new_peak = peak_max;
         end
         mped_pkg::OP_BATCH_END: begin
            new_peak = '0;
            if (abnormal) begin
               new_nrm = '0;
               new_abn = abn_inc;
               if (KW'(abn_inc) >= KW'(confirm)) begin
                  new_det = 1'b1;
               end
            end else begin
               new_abn = '0;
               if (cur_det) begin
                  new_nrm = nrm_inc;
                  if (KW'(nrm_inc) >= KW'(recover)) begin
                     new_det = 1'b0;
                     new_nrm = '0;
                  end
               end
            end
         end
         default: begin
            new_peak = cur_peak;
         end
      endcase
   end

   assign new_rec = {new_det, new_nrm, new_abn, new_peak};

   assign is_end    = e_op_ff == mped_pkg::OP_BATCH_END;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign commit    = e_valid_ff && (!is_end || out_free);
   assign e_advance = !e_valid_ff || commit;
   assign q_ready   = e_advance;
   assign pop       = q_valid && e_advance;
   assign writes    = commit && (e_op_ff == mped_pkg::OP_SAMPLE || is_end);

   always_comb begin
      e_valid_in = e_advance ? q_valid : e_valid_ff;
      fwd_in     = pop ? (writes && (e_idx == head_idx)) : (fwd_ff && !e_advance);
      valid_in   = valid_ff;
      if (commit && e_op_ff == mped_pkg::OP_CLEAR) begin
         valid_in = '0;
      end else if (writes) begin
         valid_in[e_idx] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (commit && is_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_valid_ff   <= e_valid_in;
         fwd_ff       <= fwd_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         e_op_ff    <= head_op;
         e_ch_ff    <= head_ch;
         e_mag_ff   <= head_mag;
         rdata_ff   <= state_mem[head_idx];
         fwd_rec_ff <= new_rec;
      end
      if (writes) begin
         state_mem[e_idx] <= new_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && is_end) begin
         rsp_ch_ff   <= e_ch_ff;
         rsp_peak_ff <= peak_max;
         rsp_abn_ff  <= abnormal;
         rsp_det_ff  <= new_det;
         rsp_chg_ff  <= new_det != cur_det;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_chg_ff, rsp_det_ff, rsp_abn_ff, rsp_peak_ff, rsp_ch_ff});

   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      (commit && e_op_ff == mped_pkg::OP_CLEAR) |=> (valid_ff == '0))
      else $error("Channel state still valid after a clear request.");

   a_end_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (commit && is_end) |=> rsp_valid_ff)
      else $error("Finished batch did not produce a response.");

   a_rise_needs_abnormal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_chg_ff && rsp_det_ff) |-> rsp_abn_ff)
      else $error("Detection set on a quiet batch.");

   a_fall_needs_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_chg_ff && !rsp_det_ff) |-> !rsp_abn_ff)
      else $error("Detection cleared on an abnormal batch.");

   a_fwd_needs_stage: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> e_valid_ff)
      else $error("Forwarded state held without a request in the execute stage.");

endmodule

FILE: src/multichannel_peak_event_detector_core.sv
`timescale 1ns / 1ps
// A batch end passes through the queue, the execute stage and the response register.
// Throughput: one request per cycle, also on the same channel, while the response output
// is free; set by the state memory read-modify-write with forwarding of the last write.
// Reset: synchronous; clears control, the queue and the per-channel valid bits, so every
// channel reads as zero at once; the registers return to their reset values.
// ----------------------------------------------------------------------------
// Multichannel peak event detector
// Tracks the absolute peak of each channel per batch and raises or clears an
// event flag after a run of abnormal or quiet batches.
// ----------------------------------------------------------------------------
module multichannel_peak_event_detector_core #(
   parameter  int CHANNELS    = mped_pkg::CHANNELS_DEFAULT,
   parameter  int SAMPLE_BITS = mped_pkg::SAMPLE_BITS_DEFAULT,
   parameter  int COUNT_BITS  = mped_pkg::COUNT_BITS_DEFAULT,
   localparam int REQ_W       = ((mped_pkg::CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W       = ((mped_pkg::CHANNEL_BITS + SAMPLE_BITS + 3 + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel, sample
   input  logic [REQ_W-1:0]                   req_tdata,
   input  logic                               req_tlast,
   // command
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_channel, batch_peak, batch_abnormal, detected, changed
   output logic [RSP_W-1:0]                   rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mped_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mped_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [mped_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int ENTRY_W = SAMPLE_BITS + mped_pkg::CHANNEL_BITS + mped_pkg::OP_BITS;

   mped_pkg::cfg_type  cfg;
   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   mped_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mped_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .REQ_W       (REQ_W),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mped_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mped_back #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .ENTRY_W     (ENTRY_W),
      .RSP_W       (RSP_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_data     (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
